/* rtl/core/fppt_pkg.sv */
// ----------------------------------------------------------------------------
// fppt_pkg: shared types and constants of the point transform core
// Command codes, queue entry layout and the Q4.12 scaling helper.
// ----------------------------------------------------------------------------
package fppt_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned MatW      = 16;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned Dims      = 3;
  localparam int unsigned MatSlots  = Dims * Dims;
  localparam int unsigned ProdW     = MatW + CoordW;
  localparam int unsigned FracBits  = 12;
  localparam int unsigned InDataW   = 152;
  localparam int unsigned OutDataW  = Dims * CoordW;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_MAT  = 2'd0,
    CMD_LOAD_OFF  = 2'd1,
    CMD_ROTATE    = 2'd2,
    CMD_ROT_XLATE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_LOAD_MAT = 2'd0,
    OP_LOAD_OFF = 2'd1,
    OP_XFORM    = 2'd2
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic                         translate;
    logic [SlotW-1:0]             slot;
    logic [CoordW-1:0]            value;
    logic [Dims-1:0][CoordW-1:0]  point;
  } qent_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } qstat_t;

  // Divide a Q4.12 product by 2^FracBits, truncating toward zero; keep the low word.
  function automatic logic [CoordW-1:0] div_q12(logic signed [ProdW-1:0] prod);
    logic [ProdW-1:0] adj;
    adj = prod + (prod[ProdW-1] ? ProdW'((1 << FracBits) - 1) : ProdW'(0));
    return adj[FracBits+CoordW-1:FracBits];
  endfunction

endpackage

/* rtl/core/fixed_point_point_transform_core.sv */
// ----------------------------------------------------------------------------
// fixed_point_point_transform_core: 3x3 Q4.12 matrix and translation on points
// Loads set matrix entries and offsets; transforms give one point per request.
//
//   channel | dir | tdata (low bit up)                           | tuser
//   s_axis  | in  | slot, matrix_value, offset_value, x, y, z, 0 | command
//   m_axis  | out | out_x, out_y, out_z                          | -
//
// One request per cycle in both directions while m_axis is not stalled; a
// transform reaches m_axis through the queue write and then the multiply,
// scale and sum stages.
// Loads give no output and take effect for every later transform.
// Reset clears the matrix and offsets to zero and empties the pipeline.
// A stalled m_axis holds the pipeline; s_axis keeps taking requests until the
// two-entry op queue fills.
// ----------------------------------------------------------------------------
module fixed_point_point_transform_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // slot[3:0], matrix_value[19:4], offset_value[51:20], point_x[83:52],
  // point_y[115:84], point_z[147:116], zero pad [151:148]
  input  logic [fppt_pkg::InDataW-1:0]       s_axis_tdata,
  // command[1:0]
  input  logic [fppt_pkg::CmdW-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [fppt_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned SlotLo = 0;
  localparam int unsigned MatLo  = SlotLo + fppt_pkg::SlotW;
  localparam int unsigned OffLo  = MatLo + fppt_pkg::MatW;
  localparam int unsigned PtLo   = OffLo + fppt_pkg::CoordW;
  localparam int unsigned PtW    = fppt_pkg::Dims * fppt_pkg::CoordW;

  fppt_pkg::qent_t  push_entry;
  fppt_pkg::qent_t  head;
  fppt_pkg::qstat_t qstat;
  logic             push;
  logic             pop;
  logic             req_valid;

  assign s_axis_tready = !qstat.full;
  assign req_valid     = s_axis_tvalid && s_axis_tready;

  fppt_front u_front (
    .req_valid_i    (req_valid),
    .command_i      (s_axis_tuser),
    .slot_i         (s_axis_tdata[MatLo-1:SlotLo]),
    .matrix_value_i (s_axis_tdata[OffLo-1:MatLo]),
    .offset_value_i (s_axis_tdata[PtLo-1:OffLo]),
    .point_i        (s_axis_tdata[PtLo+PtW-1:PtLo]),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  fppt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .stat_o       (qstat)
  );

  fppt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

endmodule

/* rtl/core/fppt_front.sv */
// ----------------------------------------------------------------------------
// fppt_front: request decode
// Splits an incoming request into a load or transform op and drops loads
// aimed at a slot that does not exist.
// ----------------------------------------------------------------------------
module fppt_front (
  input  logic                              req_valid_i,
  input  logic [fppt_pkg::CmdW-1:0]         command_i,
  input  logic [fppt_pkg::SlotW-1:0]        slot_i,
  input  logic signed [fppt_pkg::MatW-1:0]  matrix_value_i,
  input  logic signed [fppt_pkg::CoordW-1:0] offset_value_i,
  input  logic [fppt_pkg::Dims-1:0][fppt_pkg::CoordW-1:0] point_i,
  output logic                              push_o,
  output fppt_pkg::qent_t                   entry_o
);

  logic keep;

  always_comb begin
    keep              = 1'b0;
    entry_o.op        = fppt_pkg::OP_XFORM;
    entry_o.translate = 1'b0;
    entry_o.slot      = slot_i;
    entry_o.value     = fppt_pkg::CoordW'(offset_value_i);
    entry_o.point     = point_i;
    case (fppt_pkg::cmd_e'(command_i))
      fppt_pkg::CMD_LOAD_MAT: begin
        keep          = (slot_i < fppt_pkg::SlotW'(fppt_pkg::MatSlots));
        entry_o.op    = fppt_pkg::OP_LOAD_MAT;
        entry_o.value = fppt_pkg::CoordW'(matrix_value_i);
      end
      fppt_pkg::CMD_LOAD_OFF: begin
        keep       = (slot_i < fppt_pkg::SlotW'(fppt_pkg::Dims));
        entry_o.op = fppt_pkg::OP_LOAD_OFF;
      end
      fppt_pkg::CMD_ROTATE: begin
        keep = 1'b1;
      end
      fppt_pkg::CMD_ROT_XLATE: begin
        keep              = 1'b1;
        entry_o.translate = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Out-of-range loads are taken and dropped here.
  assign push_o = req_valid_i && keep;

endmodule

/* rtl/core/fppt_queue.sv */
// ----------------------------------------------------------------------------
// fppt_queue: op queue between decode and execute
// Small FIFO that lets the front take requests while the back stalls.
// ----------------------------------------------------------------------------
module fppt_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fppt_pkg::qent_t        push_entry_i,
  input  logic                   pop_i,
  output fppt_pkg::qent_t        head_o,
  output fppt_pkg::qstat_t       stat_o
);

  fppt_pkg::qent_t                mem_q [fppt_pkg::QueueDepth];
  logic [fppt_pkg::QPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [fppt_pkg::QPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [fppt_pkg::QCntW-1:0]     count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == fppt_pkg::QPtrW'(fppt_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == fppt_pkg::QPtrW'(fppt_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.full      = (count_q == fppt_pkg::QCntW'(fppt_pkg::QueueDepth));

endmodule

/* rtl/core/fppt_back.sv */
// ----------------------------------------------------------------------------
// fppt_back: execute pipeline
// Applies loads to the matrix and offset stores and runs transforms through
// multiply, scale and sum stages into the output register.
// ----------------------------------------------------------------------------
module fppt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fppt_pkg::qent_t             head_i,
  input  fppt_pkg::qstat_t            qstat_i,
  output logic                        pop_o,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [fppt_pkg::OutDataW-1:0] res_data_o
);

  localparam int unsigned N = fppt_pkg::Dims;

  logic signed [fppt_pkg::MatW-1:0]   mat_q  [fppt_pkg::MatSlots];
  logic [fppt_pkg::CoordW-1:0]        off_q  [N];

  logic                               v1_q, v2_q, out_valid_q;
  logic signed [fppt_pkg::ProdW-1:0]  prod_q [fppt_pkg::MatSlots];
  logic [fppt_pkg::CoordW-1:0]        quot_q [fppt_pkg::MatSlots];
  logic [fppt_pkg::CoordW-1:0]        off1_q [N];
  logic [fppt_pkg::CoordW-1:0]        off2_q [N];
  logic [N-1:0][fppt_pkg::CoordW-1:0] out_q;

  logic adv;
  logic issue;

  // Whole pipeline moves when the output register is free or being taken.
  assign adv   = !out_valid_q || res_ready_i;
  assign pop_o = qstat_i.not_empty && adv;
  assign issue = pop_o && (head_i.op == fppt_pkg::OP_XFORM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fppt_pkg::MatSlots; i++) begin
        mat_q[i] <= '0;
      end
      for (int c = 0; c < N; c++) begin
        off_q[c] <= '0;
      end
    end else if (pop_o) begin
      if (head_i.op == fppt_pkg::OP_LOAD_MAT) begin
        mat_q[head_i.slot] <= head_i.value[fppt_pkg::MatW-1:0];
      end
      if (head_i.op == fppt_pkg::OP_LOAD_OFF) begin
        off_q[head_i.slot[1:0]] <= head_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        for (int c = 0; c < N; c++) begin
          prod_q[k*N+c] <= fppt_pkg::ProdW'(mat_q[k*N+c]) *
                           fppt_pkg::ProdW'($signed(head_i.point[k]));
        end
      end
      for (int c = 0; c < N; c++) begin
        off1_q[c] <= head_i.translate ? off_q[c] : '0;
        off2_q[c] <= off1_q[c];
      end
      for (int i = 0; i < fppt_pkg::MatSlots; i++) begin
        quot_q[i] <= fppt_pkg::div_q12(prod_q[i]);
      end
      for (int c = 0; c < N; c++) begin
        out_q[c] <= quot_q[c] + quot_q[N+c] + quot_q[2*N+c] + off2_q[c];
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_data_o  = out_q;

endmodule

/* rtl/core/fppt_checker.sv */
// ----------------------------------------------------------------------------
// fppt_checker: port-level checks of the point transform core
// Watches reset, output hold and input back-pressure.
// ----------------------------------------------------------------------------
module fppt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [fppt_pkg::OutDataW-1:0]  m_axis_tdata
);

  // Reset empties the pipeline at once.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // The queue only fills behind a stalled output.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

endmodule

bind fixed_point_point_transform_core fppt_checker u_fppt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/fixed_point_point_transform_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_point_transform_core_tb: self-checking bench for the point transform
// Streams matrix loads, offset loads and point transforms with random gaps on
// both sides, predicts every transformed point and compares it field by field.
// ----------------------------------------------------------------------------
module fixed_point_point_transform_core_tb;
  import fppt_pkg::*;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned RandItems   = 1500;
  localparam int unsigned TailItems   = 200;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned SlotMax     = (1 << SlotW) - 1;

  // s_axis tdata layout, lowest field last
  typedef struct packed {
    logic [3:0]               pad;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] offset;
    logic signed [MatW-1:0]   entry;
    logic [SlotW-1:0]         slot;
  } xform_req_t;

  // m_axis tdata layout, lowest field last
  typedef struct packed {
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } point_t;

  class xform_board;
    logic signed [MatW-1:0]   mat_q12 [MatSlots];
    logic signed [CoordW-1:0] offsets [Dims];
    point_t                   expected_points [$];
    int unsigned              mismatches;

    function new();
      foreach (mat_q12[i]) mat_q12[i] = '0;
      foreach (offsets[i]) offsets[i] = '0;
      mismatches = 0;
    endfunction

    // Row vector times matrix; scale each product on its own, truncating toward zero.
    function logic [CoordW-1:0] rotate_column(int unsigned col, xform_req_t req);
      longint pt [Dims];
      longint acc;
      pt[0] = longint'($signed(req.x));
      pt[1] = longint'($signed(req.y));
      pt[2] = longint'($signed(req.z));
      acc = 0;
      for (int k = 0; k < Dims; k++)
        acc += longint'(mat_q12[k * Dims + col]) * pt[k] / (longint'(1) << FracBits);
      return acc[CoordW-1:0];
    endfunction

    function void note_request(cmd_e cmd, xform_req_t req);
      point_t pt;
      case (cmd)
        CMD_LOAD_MAT: if (req.slot < MatSlots) mat_q12[req.slot] = req.entry;
        CMD_LOAD_OFF: if (req.slot < Dims) offsets[req.slot[1:0]] = req.offset;
        default: begin
          pt.x = rotate_column(0, req);
          pt.y = rotate_column(1, req);
          pt.z = rotate_column(2, req);
          if (cmd == CMD_ROT_XLATE) begin
            pt.x = pt.x + offsets[0];
            pt.y = pt.y + offsets[1];
            pt.z = pt.z + offsets[2];
          end
          expected_points.push_back(pt);
        end
      endcase
    endfunction

    function void flag(string what, logic [CoordW-1:0] want, logic [CoordW-1:0] got);
      mismatches++;
      if (mismatches <= MaxReports)
        $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    function void check_result(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("result %h with no transform pending", got);
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x) flag("out_x", want.x, got.x);
      if (got.y !== want.y) flag("out_y", want.y, got.y);
      if (got.z !== want.z) flag("out_z", want.z, got.z);
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [CmdW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  xform_board  board;
  logic        tail_mode = 1'b0;
  logic        sink_holding = 1'b0;
  int unsigned sent_count = 0;

  fixed_point_point_transform_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic xform_req_t random_req();
    xform_req_t req;
    req.pad    = '0;
    req.x      = $urandom;
    req.y      = $urandom;
    req.z      = $urandom;
    req.offset = $urandom;
    req.entry  = MatW'($urandom);
    req.slot   = SlotW'($urandom);
    return req;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    logic [CoordW-1:0] corners [5] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1};
    case ($urandom_range(0, 3))
      0: return corners[$urandom_range(0, 4)];
      1: return CoordW'(int'($urandom_range(0, 16383)) - 8192);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [MatW-1:0] rand_entry();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      1: return MatW'(($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 64)) - 32);
      default: return MatW'($urandom);
    endcase
  endfunction

  // Drive one request, with an occasional gap before it, and wait for the handshake.
  task automatic offer(input cmd_e cmd, input xform_req_t req);
    if (!tail_mode && !sink_holding && (sent_count / 80) % 4 != 3 &&
        $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_request(cmd, req);
    sent_count++;
  endtask

  task automatic load_entry(input logic [SlotW-1:0] slot, input logic [MatW-1:0] value);
    xform_req_t req;
    req = random_req();
    req.slot  = slot;
    req.entry = value;
    offer(CMD_LOAD_MAT, req);
  endtask

  task automatic load_offset(input logic [SlotW-1:0] slot, input logic [CoordW-1:0] value);
    xform_req_t req;
    req = random_req();
    req.slot   = slot;
    req.offset = value;
    offer(CMD_LOAD_OFF, req);
  endtask

  task automatic transform(input cmd_e cmd, input logic [CoordW-1:0] x,
                           input logic [CoordW-1:0] y, input logic [CoordW-1:0] z);
    xform_req_t req;
    req = random_req();
    req.x = x;
    req.y = y;
    req.z = z;
    offer(cmd, req);
  endtask

  // Receiver pacing: random stall bursts, calm stretches and a couple of long holds.
  initial begin : sink_pacing
    int unsigned cyc;
    int unsigned gap;
    int unsigned next_hold;
    int unsigned holds_left;
    m_axis_tready = 1'b0;
    cyc = 0;
    next_hold = 400;
    holds_left = 2;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (!tail_mode && holds_left != 0 && cyc >= next_hold) begin
        m_axis_tready <= 1'b0;
        sink_holding = 1'b1;
        repeat (HoldCycles - 1) @(negedge clk_i);
        cyc += HoldCycles - 1;
        sink_holding = 1'b0;
        holds_left--;
        next_hold = cyc + 2600;
      end else if (!tail_mode && (cyc / 500) % 4 != 1 && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 18);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
        cyc += gap - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned pick;
    board = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = CMD_LOAD_MAT;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero matrix after reset, then offsets at the extremes
    transform(CMD_ROTATE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    load_offset(4'd0, 32'h7fff_ffff);
    load_offset(4'd1, 32'h8000_0000);
    load_offset(4'd2, 32'hffff_ffff);
    // Out-of-range offset slot: drop
    load_offset(4'hf, 32'h1234_5678);
    transform(CMD_ROT_XLATE, 32'd1, 32'd2, 32'd3);
    load_entry(4'd0, 16'h7fff);
    load_entry(4'd1, 16'h8000);
    load_entry(4'd2, 16'h1000);
    load_entry(4'd3, 16'hf000);
    load_entry(4'd4, 16'h0001);
    load_entry(4'd5, 16'hffff);
    load_entry(4'd6, 16'h0800);
    load_entry(4'd7, 16'h8001);
    load_entry(4'd8, 16'h7ffe);
    // Out-of-range matrix slots: drop
    load_entry(4'd9, 16'h1234);
    load_entry(4'hf, 16'h4321);
    transform(CMD_ROTATE, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    transform(CMD_ROT_XLATE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // Small products of both signs exercise truncation toward zero
    transform(CMD_ROTATE, 32'hffff_ffff, 32'd1, -32'sd4095);
    transform(CMD_ROT_XLATE, 32'd0, 32'd0, 32'd0);
    transform(CMD_ROTATE, 32'd4095, -32'sd4097, 32'h7fff_ffff);
    transform(CMD_ROT_XLATE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);

    counted = 0;
    while (counted < RandItems) begin
      tail_mode = (counted + TailItems >= RandItems);
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        load_entry(SlotW'($urandom_range(0, MatSlots - 1)), rand_entry());
        counted++;
      end else if (pick < 23) begin
        load_entry(SlotW'($urandom_range(MatSlots, SlotMax)), rand_entry());
      end else if (pick < 33) begin
        load_offset(SlotW'($urandom_range(0, Dims - 1)), rand_coord());
        counted++;
      end else if (pick < 36) begin
        load_offset(SlotW'($urandom_range(Dims, SlotMax)), rand_coord());
      end else if (pick < 68) begin
        transform(CMD_ROTATE, rand_coord(), rand_coord(), rand_coord());
        counted++;
      end else begin
        transform(CMD_ROT_XLATE, rand_coord(), rand_coord(), rand_coord());
        counted++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.expected_points.size() != 0) @(posedge clk_i);
    // Catch any stray output after the last expected point
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/fppt_pkg.sv
rtl/core/fppt_front.sv
rtl/core/fppt_queue.sv
rtl/core/fppt_back.sv
rtl/core/fixed_point_point_transform_core.sv
rtl/core/fppt_checker.sv
test/fixed_point_point_transform_core_tb.sv
